FILE: rtl/core/lpid_pkg.sv
// ----------------------------------------------------------------------------
// lpid_pkg
// Shared types and constants for the length-prefixed image deframer.
// ----------------------------------------------------------------------------
package lpid_pkg;

  localparam int          LENGTH_BITS_DEF = 31;
  localparam int          HEADER_BYTES    = 16;
  localparam int          HDR_COUNT_W     = 5;
  localparam logic [31:0] MAGIC_RESET     = 32'h00ab_cdef;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_BAD     = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         payload_byte;
    logic               section;
    logic signed [31:0] frame_stamp;
    logic               last;
  } result_t;

endpackage

FILE: rtl/core/lpid_byte_if.sv
// ----------------------------------------------------------------------------
// lpid_byte_if
// Valid/ready channel carrying one stream byte per word.
// ----------------------------------------------------------------------------
interface lpid_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

FILE: rtl/core/lpid_result_if.sv
// ----------------------------------------------------------------------------
// lpid_result_if
// Valid/ready channel carrying one deframer result per word.
// ----------------------------------------------------------------------------
interface lpid_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         payload_byte;
  logic               section;
  logic signed [31:0] frame_stamp;
  logic               last;

  modport source (
    output valid, output kind, output payload_byte, output section,
    output frame_stamp, output last, input ready
  );
  modport sink (
    input valid, input kind, input payload_byte, input section,
    input frame_stamp, input last, output ready
  );
endinterface

FILE: rtl/core/lpid_in_stage.sv
// ----------------------------------------------------------------------------
// lpid_in_stage
// Input register: holds one stream byte until the core takes it.
// ----------------------------------------------------------------------------
module lpid_in_stage (
  input  logic        clk,
  input  logic        rst,
  lpid_byte_if.sink   stream,
  input  logic        take,
  output logic        stage_valid,
  output logic [7:0]  stage_byte
);

  assign stream.ready = !stage_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stream.ready) begin
      stage_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      stage_byte <= stream.data_byte;
    end
  end

endmodule

FILE: rtl/core/lpid_core.sv
// ----------------------------------------------------------------------------
// lpid_core
// Header parse, length countdown and result register of the deframer.
// ----------------------------------------------------------------------------
module lpid_core #(
  parameter int LENGTH_BITS = lpid_pkg::LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  input  logic              stage_valid,
  input  logic [7:0]        stage_byte,
  output logic              take,
  input  logic              out_ready,
  output logic              res_valid,
  output lpid_pkg::result_t res
);

  import lpid_pkg::*;

  localparam int LB = LENGTH_BITS;

  logic [31:0]            expected_magic;
  logic [HDR_COUNT_W-1:0] header_count, header_count_next;
  logic [31:0]            word_assembly, word_assembly_next;
  logic                   magic_ok, magic_ok_next;
  logic [31:0]            stamp_word, stamp_word_next;
  logic                   colour_fits, colour_fits_next;
  logic [LB-1:0]          colour_remaining, colour_remaining_next;
  logic [LB-1:0]          depth_remaining, depth_remaining_next;
  logic                   error_latched, error_latched_next;
  logic                   res_valid_next;
  result_t                res_next;
  logic                   depth_fits;

  assign take = stage_valid && (!res_valid || out_ready);

  always_comb begin
    header_count_next     = header_count;
    word_assembly_next    = word_assembly;
    magic_ok_next         = magic_ok;
    stamp_word_next       = stamp_word;
    colour_fits_next      = colour_fits;
    colour_remaining_next = colour_remaining;
    depth_remaining_next  = depth_remaining;
    error_latched_next    = error_latched;
    res_valid_next        = res_valid && !out_ready;
    res_next              = res;
    depth_fits            = 1'b0;

    if (take && !error_latched) begin
      if (header_count < HDR_COUNT_W'(HEADER_BYTES)) begin
        word_assembly_next = {stage_byte, word_assembly[31:8]};
        header_count_next  = header_count + HDR_COUNT_W'(1);
        if (header_count[1:0] == 2'd3) begin
          unique case (header_count[3:2])
            2'd0: magic_ok_next = (word_assembly_next == expected_magic);
            2'd1: stamp_word_next = word_assembly_next;
            2'd2: begin
              colour_fits_next      = (word_assembly_next[31:LB] == '0);
              colour_remaining_next = word_assembly_next[LB-1:0];
            end
            default: begin
              depth_fits           = (word_assembly_next[31:LB] == '0);
              depth_remaining_next = word_assembly_next[LB-1:0];
              res_next.payload_byte = 8'd0;
              res_next.section      = 1'b0;
              res_next.frame_stamp  = stamp_word;
              if (!(magic_ok && colour_fits && depth_fits)) begin
                error_latched_next    = 1'b1;
                colour_remaining_next = '0;
                depth_remaining_next  = '0;
                res_valid_next        = 1'b1;
                res_next.kind         = KIND_BAD;
                res_next.last         = 1'b0;
              end else if (colour_remaining == '0 && depth_remaining_next == '0) begin
                header_count_next = '0;
                res_valid_next    = 1'b1;
                res_next.kind     = KIND_EMPTY;
                res_next.last     = 1'b1;
              end
            end
          endcase
        end
      end else begin
        if (colour_remaining != '0) begin
          colour_remaining_next = colour_remaining - LB'(1);
          res_next.section      = 1'b0;
        end else begin
          depth_remaining_next = depth_remaining - LB'(1);
          res_next.section     = 1'b1;
        end
        res_valid_next        = 1'b1;
        res_next.kind         = KIND_PAYLOAD;
        res_next.payload_byte = stage_byte;
        res_next.frame_stamp  = stamp_word;
        res_next.last         = (colour_remaining_next == '0) && (depth_remaining_next == '0);
        if (res_next.last) begin
          header_count_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic   <= MAGIC_RESET;
      header_count     <= '0;
      word_assembly    <= '0;
      magic_ok         <= 1'b0;
      stamp_word       <= '0;
      colour_fits      <= 1'b0;
      colour_remaining <= '0;
      depth_remaining  <= '0;
      error_latched    <= 1'b0;
      res_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        expected_magic <= cfg_wdata;
      end
      header_count     <= header_count_next;
      word_assembly    <= word_assembly_next;
      magic_ok         <= magic_ok_next;
      stamp_word       <= stamp_word_next;
      colour_fits      <= colour_fits_next;
      colour_remaining <= colour_remaining_next;
      depth_remaining  <= depth_remaining_next;
      error_latched    <= error_latched_next;
      res_valid        <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

FILE: rtl/core/length_prefixed_image_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_image_deframer
// Splits a byte stream of length-prefixed colour/depth frames into tagged
// payload bytes, empty-frame marks and a bad-header error.
//
//   channel   dir  word contents
//   stream    in   data_byte
//   result    out  kind, payload_byte, section, frame_stamp, last
//   cfg       in   cfg_we, cfg_wdata (expected_magic)
//
// One byte per cycle sustained while results are taken; each byte is
// held in the input register and its result then in the result register.
// The header/count update does at most one counter decrement per byte.
// Synchronous reset clears the counters, error latch and valid flags and
// restores expected_magic. A stalled result holds the core; the input
// register still takes one byte meanwhile.
// ----------------------------------------------------------------------------
module length_prefixed_image_deframer #(
  parameter int LENGTH_BITS = lpid_pkg::LENGTH_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  lpid_byte_if.sink    stream,
  lpid_result_if.source result
);

  import lpid_pkg::*;

  logic       take;
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       res_valid;
  result_t    res;

  lpid_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .stream      (stream),
    .take        (take),
    .stage_valid (stage_valid),
    .stage_byte  (stage_byte)
  );

  lpid_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .stage_valid (stage_valid),
    .stage_byte  (stage_byte),
    .take        (take),
    .out_ready   (result.ready),
    .res_valid   (res_valid),
    .res         (res)
  );

  assign result.valid        = res_valid;
  assign result.kind         = res.kind;
  assign result.payload_byte = res.payload_byte;
  assign result.section      = res.section;
  assign result.frame_stamp  = res.frame_stamp;
  assign result.last         = res.last;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives framed byte streams into the image deframer and checks every result
// word against a cycle-free model of the header parser and payload counters.
// Runs directed frames, a magic update in the middle of a header, random
// frames under several magic values, a long result stall, and one bad header
// at the end, after which all bytes must be swallowed.
// ----------------------------------------------------------------------------
module testbench;
  import lpid_pkg::*;

  localparam int          CLK_HALF      = 10;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          HOLD_AT       = 1000;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          PHASE_BYTES   = 360;
  localparam int          MAX_PRINTS    = 40;
  localparam int unsigned LEN_BITS      = LENGTH_BITS_DEF;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        quiet = 1'b0;

  lpid_byte_if   stream ();
  lpid_result_if result ();

  length_prefixed_image_deframer u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stream    (stream),
    .result    (result)
  );

  always #(CLK_HALF) clk = ~clk;

  logic [7:0]  stream_bytes[$];
  result_t     due_results[$];

  logic [31:0] magic_cfg = MAGIC_RESET;
  logic [4:0]  hdr_cnt = '0;
  logic [31:0] word_sr = '0;
  logic        magic_match = 1'b0;
  logic [31:0] stamp_reg = '0;
  logic [31:0] colour_left = '0;
  logic [31:0] depth_left = '0;
  logic        err_latched = 1'b0;

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_taken = 0;
  int unsigned frames_loaded = 0;
  int unsigned magic_writes = 0;
  int unsigned payload_seen = 0;
  int unsigned empty_seen = 0;
  int unsigned bad_seen = 0;
  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned hold_left;
  logic        hold_done;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS)
      $display("cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    stream_bytes = {stream_bytes, b};
  endtask

  task automatic queue_due(input result_t r);
    due_results = {due_results, r};
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    result_t    r;
    logic [4:0] pos;
    r = '0;
    if (err_latched)
      return;
    if (hdr_cnt < HEADER_BYTES) begin
      pos = hdr_cnt;
      word_sr = {b, word_sr[31:8]};
      hdr_cnt = hdr_cnt + 5'd1;
      if (pos[1:0] != 2'd3)
        return;
      case (pos[3:2])
        2'd0: magic_match = (word_sr == magic_cfg);
        2'd1: stamp_reg = word_sr;
        2'd2: colour_left = word_sr;
        default: begin
          depth_left = word_sr;
          r.frame_stamp = stamp_reg;
          if (!magic_match || (colour_left >> LEN_BITS) != 0 ||
              (depth_left >> LEN_BITS) != 0) begin
            err_latched = 1'b1;
            colour_left = '0;
            depth_left = '0;
            r.kind = KIND_BAD;
            queue_due(r);
          end else if (colour_left == 0 && depth_left == 0) begin
            hdr_cnt = '0;
            r.kind = KIND_EMPTY;
            r.last = 1'b1;
            queue_due(r);
          end
        end
      endcase
    end else begin
      r.kind = KIND_PAYLOAD;
      r.payload_byte = b;
      r.frame_stamp = stamp_reg;
      if (colour_left != 0) begin
        colour_left = colour_left - 1;
        r.section = 1'b0;
      end else begin
        depth_left = depth_left - 1;
        r.section = 1'b1;
      end
      if (colour_left == 0 && depth_left == 0) begin
        r.last = 1'b1;
        hdr_cnt = '0;
      end
      queue_due(r);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing due: kind %0d byte %h",
                                result.kind, result.payload_byte));
      return;
    end
    want = due_results.pop_front();
    case (want.kind)
      KIND_PAYLOAD: payload_seen++;
      KIND_EMPTY:   empty_seen++;
      default:      bad_seen++;
    endcase
    if (result.kind !== want.kind)
      report_mismatch($sformatf("kind got %0d want %0d", result.kind, want.kind));
    if (result.payload_byte !== want.payload_byte)
      report_mismatch($sformatf("payload_byte got %h want %h",
                                result.payload_byte, want.payload_byte));
    if (result.section !== want.section)
      report_mismatch($sformatf("section got %b want %b", result.section, want.section));
    if (result.frame_stamp !== want.frame_stamp)
      report_mismatch($sformatf("frame_stamp got %h want %h",
                                result.frame_stamp, want.frame_stamp));
    if (result.last !== want.last)
      report_mismatch($sformatf("last got %b want %b", result.last, want.last));
  endtask

  // driver: hold a word until taken, then advance or idle
  always @(posedge clk) begin
    if (rst) begin
      stream.valid <= 1'b0;
      stream.data_byte <= '0;
      send_gap <= 0;
    end else begin
      if (stream.valid && stream.ready) begin
        deframe_byte(stream.data_byte);
        bytes_taken <= bytes_taken + 1;
      end
      if (!stream.valid || stream.ready) begin
        if (send_gap != 0) begin
          stream.valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          stream.valid <= 1'b0;
          send_gap <= $urandom_range(0, 11);
        end else if (stream_bytes.size() != 0) begin
          stream.valid <= 1'b1;
          stream.data_byte <= stream_bytes.pop_front();
        end else begin
          stream.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off while the sender keeps going
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && bytes_taken >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: check taken results, stall in bursts
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (result.valid && result.ready)
        check_result();
      if (recv_stall != 0) begin
        result.ready <= 1'b0;
        recv_stall <= recv_stall - 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        result.ready <= 1'b0;
        recv_stall <= $urandom_range(0, 11);
      end else begin
        result.ready <= (hold_left == 0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic load_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++)
      queue_byte(w[8*i +: 8]);
  endtask

  task automatic load_frame(input logic [31:0] magic, input logic [31:0] stamp,
                            input logic [31:0] clen, input logic [31:0] dlen);
    load_word(magic);
    load_word(stamp);
    load_word(clen);
    load_word(dlen);
    for (int unsigned i = 0; i < clen + dlen; i++)
      queue_byte(8'($urandom_range(0, 255)));
    frames_loaded++;
  endtask

  task automatic load_random_frame(input logic [31:0] magic);
    int unsigned shape;
    int unsigned top;
    int unsigned clen;
    int unsigned dlen;
    shape = $urandom_range(0, 19);
    top = ($urandom_range(0, 19) == 0) ? 200 : 24;
    clen = $urandom_range(1, top);
    dlen = $urandom_range(1, top);
    if (shape < 2) begin
      clen = 0;
      dlen = 0;
    end else if (shape < 5) begin
      dlen = 0;
    end else if (shape < 8) begin
      clen = 0;
    end
    load_frame(magic, $urandom, clen, dlen);
  endtask

  task automatic wait_idle();
    while (stream_bytes.size() != 0 || stream.valid || due_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_magic(input logic [31:0] m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    magic_cfg = m;
    magic_writes++;
  endtask

  initial begin
    logic [31:0] phase_magic[4];
    logic [31:0] m;
    logic [31:0] bad_word;
    int unsigned flavor;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    stream.valid = 1'b0;
    stream.data_byte = '0;
    result.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed frames under the reset magic
    load_frame(MAGIC_RESET, 32'h8000_0000, 0, 0);
    load_frame(MAGIC_RESET, 32'h7fff_ffff, 1, 0);
    load_frame(MAGIC_RESET, 32'hffff_ffff, 0, 1);
    load_frame(MAGIC_RESET, 32'h0000_0000, 2, 3);
    wait_idle();

    // magic changes after the first header word is in: this frame still passes
    load_word(MAGIC_RESET);
    wait_idle();
    write_magic(32'h0000_0000);
    load_word(32'h1234_5678);
    load_word(32'd1);
    load_word(32'd1);
    queue_byte(8'h00);
    queue_byte(8'hff);
    frames_loaded++;
    load_frame(32'h0000_0000, 32'h0000_0001, 0, 0);
    wait_idle();

    phase_magic[0] = 32'hffff_ffff;
    phase_magic[1] = $urandom;
    phase_magic[2] = 32'h0000_0000;
    phase_magic[3] = MAGIC_RESET;
    for (int p = 0; p < 4; p++) begin
      write_magic(phase_magic[p]);
      while (stream_bytes.size() < PHASE_BYTES)
        load_random_frame(phase_magic[p]);
      wait_idle();
    end

    // last stretch at full rate, ending in a bad header
    quiet <= 1'b1;
    m = $urandom;
    write_magic(m);
    load_random_frame(m);
    load_random_frame(m);
    flavor = $urandom_range(0, 2);
    bad_word = {1'b1, 31'($urandom)};
    load_word((flavor == 0) ? (m ^ (32'd1 << $urandom_range(0, 31))) : m);
    load_word($urandom);
    load_word((flavor == 1) ? bad_word : 32'($urandom_range(0, 8)));
    load_word((flavor == 2) ? bad_word : 32'($urandom_range(0, 8)));
    for (int i = 0; i < 20; i++)
      queue_byte(8'($urandom_range(0, 255)));
    wait_idle();

    while (due_results.size() != 0) begin
      report_mismatch("expected result never arrived");
      void'(due_results.pop_front());
    end
    $display("%0d frames, %0d bytes taken, %0d magic writes", frames_loaded, bytes_taken,
             magic_writes);
    $display("results: %0d payload, %0d empty, %0d bad header; %0d mismatches",
             payload_seen, empty_seen, bad_seen, mismatches);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
